// File: hdl/lrte_pkg.sv
// Shared types, constants and helper functions for the line and rectangle expander.
`timescale 1ns / 1ps
package lrte_pkg;

  localparam int VERTICES_PER_PRIMITIVE = 6;
  localparam int DIM_W = 13;
  localparam int COORD_W = 30;

  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 46;
  localparam int DIV_Q_W = 26;
  localparam int DIV_CMP_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_STAGES = DIV_Q_W + 1;

  localparam int SQRT_W = 64;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_STAGES = SQRT_STEPS + 1;
  localparam int ROOT_W = 32;

  localparam int NORM_STAGES = 6;
  localparam int SHIFT_W = 6;

  localparam logic [DIM_W-1:0] CANVAS_RESET = 13'd1024;
  localparam logic signed [COORD_W-1:0] ONE_Q13 = 30'sd8192;

  localparam logic OP_LINE = 1'b0;
  localparam logic OP_RECT = 1'b1;

  localparam logic REG_CANVAS_WIDTH = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [2:0] LAST_VERTEX = 3'(VERTICES_PER_PRIMITIVE - 1);

  typedef struct packed {
    logic op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [11:0] lw;
    logic [31:0] col;
  } prim_t;

  typedef struct packed {
    logic op;
    logic zero;
    logic [11:0] lw;
    logic [31:0] col;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } geo_t;

  function automatic logic [16:0] abs16(logic signed [15:0] v);
    logic signed [16:0] t;
    t = 17'(v);
    return t[16] ? 17'(-t) : 17'(t);
  endfunction

  function automatic logic [COORD_W-1:0] abs_coord(logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic [DIV_NUM_W-1:0] scale_num(logic signed [15:0] v,
                                                     logic [DIM_W-1:0] dim);
    logic [16:0] m;
    m = abs16(v);
    return DIV_NUM_W'({m, 10'b0}) + DIV_NUM_W'(dim >> 1);
  endfunction

  function automatic logic signed [COORD_W-1:0] apply_sign(logic [DIV_Q_W-1:0] q,
                                                           logic neg);
    logic signed [COORD_W-1:0] t;
    t = signed'(COORD_W'(q));
    return neg ? -t : t;
  endfunction

  function automatic logic [15:0] sat16(logic signed [COORD_W-1:0] v);
    logic [15:0] r;
    if (v > 30'sd32767) r = 16'h7FFF;
    else if (v < -30'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [1:0] corner_sel(logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd0;
      3'd4: c = 2'd2;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/lrte_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module lrte_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lrte_pkg::DIV_NUM_W-1:0] num,
  input  logic [lrte_pkg::DIV_DEN_W-1:0] den,
  output logic [lrte_pkg::DIV_Q_W-1:0]   quot
);
  import lrte_pkg::*;

  logic [DIV_NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_DEN_W-1:0] den_r [DIV_Q_W];
  logic [DIV_Q_W-1:0]   q_r   [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar g = 0; g < DIV_Q_W; g++) begin : g_step
    localparam int Bit = DIV_Q_W - 1 - g;
    logic [DIV_CMP_W-1:0] trial;
    logic                 take;

    assign trial = DIV_CMP_W'(den_r[g]) << Bit;
    assign take  = DIV_CMP_W'(rem_r[g]) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1] <= take ? DIV_NUM_W'(DIV_CMP_W'(rem_r[g]) - trial) : rem_r[g];
        q_r[g+1]   <= q_r[g] | (take ? (DIV_Q_W'(1) << Bit) : DIV_Q_W'(0));
      end
    end

    if (g < DIV_Q_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[g+1] <= den_r[g];
        end
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule

// File: hdl/lrte_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module lrte_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lrte_pkg::SQRT_W-1:0] x,
  output logic [lrte_pkg::ROOT_W-1:0] root
);
  import lrte_pkg::*;

  logic [SQRT_W-1:0] v_r [SQRT_STAGES];
  logic [SQRT_W-1:0] r_r [SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= x;
      r_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam int Sh = 2 * (SQRT_STEPS - 1 - g);
    logic [SQRT_W-1:0] b;
    logic [SQRT_W:0]   sum;
    logic              take;

    assign b    = SQRT_W'(1) << Sh;
    assign sum  = (SQRT_W+1)'(r_r[g]) + (SQRT_W+1)'(b);
    assign take = (SQRT_W+1)'(v_r[g]) >= sum;

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1] <= take ? SQRT_W'((SQRT_W+1)'(v_r[g]) - sum) : v_r[g];
        r_r[g+1] <= take ? (r_r[g] >> 1) + b : r_r[g] >> 1;
      end
    end
  end

  assign root = r_r[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// File: hdl/line_and_rect_triangle_expander_unit.sv
// Top level: expands wide lines and filled rectangles into six clip-space vertices.
// Throughput: one vertex word per cycle while out_tready is high, set by the single
// vertex output port; the arithmetic pipeline takes a word every cycle except while
// a finished primitive waits for that port to become free.
// Reset: synchronous active-low rst_n clears all valid bits and sets both canvas
// dimensions to 1024.
`timescale 1ns / 1ps
module line_and_rect_triangle_expander_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, second_x, second_y, line_width, red, green, blue, alpha, zero pad
  input  logic [111:0] in_tdata,
  // op
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_x, vertex_y, red, green, blue, alpha
  output logic [63:0]  out_tdata,
  output logic         out_tlast
);
  import lrte_pkg::*;

  logic [DIM_W-1:0] width_r, height_r, w_eff, h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CANVAS_RESET;
      height_r <= CANVAS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  width_r  <= cfg_data;
        REG_CANVAS_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_r == '0) ? DIM_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) : height_r;

  logic adv, ser_free, ser_load;

  // Input capture.
  prim_t a_r;
  logic  a_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r.op  <= in_tuser;
      a_r.ax  <= in_tdata[15:0];
      a_r.ay  <= in_tdata[31:16];
      a_r.bx  <= in_tdata[47:32];
      a_r.by  <= in_tdata[63:48];
      a_r.lw  <= in_tdata[75:64];
      a_r.col <= in_tdata[107:76];
    end
  end

  assign in_tready = adv;

  // Screen to clip scaling dividers.
  logic [DIV_Q_W-1:0] q_ax, q_ay, q_bx, q_by;

  lrte_div u_div_ax (.clk(clk), .en(adv), .num(scale_num(a_r.ax, w_eff)),
                     .den(DIV_DEN_W'(w_eff)), .quot(q_ax));
  lrte_div u_div_ay (.clk(clk), .en(adv), .num(scale_num(a_r.ay, h_eff)),
                     .den(DIV_DEN_W'(h_eff)), .quot(q_ay));
  lrte_div u_div_bx (.clk(clk), .en(adv), .num(scale_num(a_r.bx, w_eff)),
                     .den(DIV_DEN_W'(w_eff)), .quot(q_bx));
  lrte_div u_div_by (.clk(clk), .en(adv), .num(scale_num(a_r.by, h_eff)),
                     .den(DIV_DEN_W'(h_eff)), .quot(q_by));

  prim_t                 d1_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] d1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= '0;
    else if (adv) d1_v_r <= {d1_v_r[DIV_STAGES-2:0], a_v_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r[0] <= a_r;
      for (int k = 1; k < DIV_STAGES; k++) d1_r[k] <= d1_r[k-1];
    end
  end

  // Clip positions, differences, squares and their sum.
  prim_t p_end;
  geo_t  c_nxt, c_r, d_nxt, d_r, e_r, f_r;
  logic  c_v_r, d_v_r, e_v_r, f_v_r;
  logic signed [COORD_W-1:0] sax, say, sbx, sby;
  logic signed [59:0] dx_ext, dy_ext;
  logic [59:0] e_dx2_r, e_dy2_r;
  logic [SQRT_W-1:0] f_sq_r;

  assign p_end = d1_r[DIV_STAGES-1];
  assign sax = apply_sign(q_ax, p_end.ax[15]);
  assign say = apply_sign(q_ay, p_end.ay[15]);
  assign sbx = apply_sign(q_bx, p_end.bx[15]);
  assign sby = apply_sign(q_by, p_end.by[15]);

  always_comb begin
    c_nxt      = '0;
    c_nxt.op   = p_end.op;
    c_nxt.lw   = p_end.lw;
    c_nxt.col  = p_end.col;
    c_nxt.px   = sax - ONE_Q13;
    c_nxt.py   = ONE_Q13 - say;
    c_nxt.ex   = (p_end.op == OP_RECT) ? sbx : sbx - ONE_Q13;
    c_nxt.ey   = (p_end.op == OP_RECT) ? sby : ONE_Q13 - sby;
  end

  always_comb begin
    d_nxt      = c_r;
    d_nxt.dx   = c_r.ex - c_r.px;
    d_nxt.dy   = c_r.ey - c_r.py;
    d_nxt.zero = (d_nxt.dx == '0) && (d_nxt.dy == '0);
  end

  assign dx_ext = 60'(d_r.dx);
  assign dy_ext = 60'(d_r.dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= d1_v_r[DIV_STAGES-1];
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r      <= c_nxt;
      d_r      <= d_nxt;
      e_r      <= d_r;
      e_dx2_r  <= 60'(dx_ext * dx_ext);
      e_dy2_r  <= 60'(dy_ext * dy_ext);
      f_r      <= e_r;
      f_sq_r   <= SQRT_W'(e_dx2_r) + SQRT_W'(e_dy2_r);
    end
  end

  // Normalization: even left shift that brings the sum to at least 2^60.
  geo_t                   n_r   [NORM_STAGES];
  logic [SQRT_W-1:0]      n_x_r [NORM_STAGES];
  logic [SHIFT_W-1:0]     n_s_r [NORM_STAGES];
  logic [NORM_STAGES-1:0] n_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n_v_r <= '0;
    else if (adv) n_v_r <= {n_v_r[NORM_STAGES-2:0], f_v_r};
  end

  for (genvar g = 0; g < NORM_STAGES - 1; g++) begin : g_norm
    localparam int Step = 16 >> g;
    logic [SQRT_W-1:0]  x_in;
    logic [SHIFT_W-1:0] s_in;
    geo_t               geo_in;
    logic               is_low;

    if (g == 0) begin : g_first
      assign x_in   = f_sq_r;
      assign s_in   = '0;
      assign geo_in = f_r;
    end else begin : g_next
      assign x_in   = n_x_r[g-1];
      assign s_in   = n_s_r[g-1];
      assign geo_in = n_r[g-1];
    end

    assign is_low = (x_in[SQRT_W-1:60-2*Step] == '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[g]   <= geo_in;
        n_x_r[g] <= is_low ? x_in << (2 * Step) : x_in;
        n_s_r[g] <= is_low ? s_in + SHIFT_W'(Step) : s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[NORM_STAGES-1]   <= n_r[NORM_STAGES-2];
      n_x_r[NORM_STAGES-1] <= n_x_r[NORM_STAGES-2] << 2;
      n_s_r[NORM_STAGES-1] <= n_s_r[NORM_STAGES-2] + SHIFT_W'(1);
    end
  end

  // Length of the normalized difference vector.
  logic [ROOT_W-1:0] len;

  lrte_sqrt u_sqrt (.clk(clk), .en(adv), .x(n_x_r[NORM_STAGES-1]), .root(len));

  geo_t                   sq_r   [SQRT_STAGES];
  logic [SHIFT_W-1:0]     sq_s_r [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] sq_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r <= '0;
    else if (adv) sq_v_r <= {sq_v_r[SQRT_STAGES-2:0], n_v_r[NORM_STAGES-1]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0]   <= n_r[NORM_STAGES-1];
      sq_s_r[0] <= n_s_r[NORM_STAGES-1];
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sq_r[k]   <= sq_r[k-1];
        sq_s_r[k] <= sq_s_r[k-1];
      end
    end
  end

  // Offset numerators and denominator.
  geo_t g_end, h_r, i_r, j_r;
  logic h_v_r, i_v_r, j_v_r;
  logic [61:0] shx, shy;
  logic [ROOT_W-1:0] h_ax_r, h_ay_r;
  logic [DIV_DEN_W-1:0] h_den_r, i_den_r, j_den_r;
  logic [43:0] i_px_r, i_py_r;
  logic [DIV_NUM_W-1:0] j_numx_r, j_numy_r;

  assign g_end = sq_r[SQRT_STAGES-1];
  assign shx = 62'(abs_coord(g_end.dy)) << sq_s_r[SQRT_STAGES-1];
  assign shy = 62'(abs_coord(g_end.dx)) << sq_s_r[SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
    end else if (adv) begin
      h_v_r <= sq_v_r[SQRT_STAGES-1];
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r      <= g_end;
      h_ax_r   <= shx[ROOT_W-1:0];
      h_ay_r   <= shy[ROOT_W-1:0];
      h_den_r  <= DIV_DEN_W'(DIV_DEN_W'(w_eff) * DIV_DEN_W'(len));
      i_r      <= h_r;
      i_px_r   <= 44'(44'(h_ax_r) * 44'(h_r.lw));
      i_py_r   <= 44'(44'(h_ay_r) * 44'(h_r.lw));
      i_den_r  <= h_den_r;
      j_r      <= i_r;
      j_numx_r <= DIV_NUM_W'({i_px_r, 9'b0}) + DIV_NUM_W'(i_den_r >> 1);
      j_numy_r <= DIV_NUM_W'({i_py_r, 9'b0}) + DIV_NUM_W'(i_den_r >> 1);
      j_den_r  <= i_den_r;
    end
  end

  // Offset dividers.
  logic [DIV_Q_W-1:0] q_ox, q_oy;

  lrte_div u_div_ox (.clk(clk), .en(adv), .num(j_numx_r), .den(j_den_r), .quot(q_ox));
  lrte_div u_div_oy (.clk(clk), .en(adv), .num(j_numy_r), .den(j_den_r), .quot(q_oy));

  geo_t                  d2_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] d2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r <= '0;
    else if (adv) d2_v_r <= {d2_v_r[DIV_STAGES-2:0], j_v_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r[0] <= j_r;
      for (int k = 1; k < DIV_STAGES; k++) d2_r[k] <= d2_r[k-1];
    end
  end

  // Signed offsets, then corners with saturation.
  geo_t o_end, k_r;
  logic k_v_r, l_v_r;
  logic signed [COORD_W-1:0] k_ox_r, k_oy_r;
  logic signed [COORD_W-1:0] cx_nxt [4];
  logic signed [COORD_W-1:0] cy_nxt [4];
  logic [15:0] l_cx_r [4];
  logic [15:0] l_cy_r [4];
  logic [31:0] l_col_r;

  assign o_end = d2_r[DIV_STAGES-1];

  always_comb begin
    if (k_r.op == OP_RECT) begin
      cx_nxt[0] = k_r.px;           cy_nxt[0] = k_r.py;
      cx_nxt[1] = k_r.px + k_r.ex;  cy_nxt[1] = k_r.py;
      cx_nxt[2] = k_r.px + k_r.ex;  cy_nxt[2] = k_r.py + k_r.ey;
      cx_nxt[3] = k_r.px;           cy_nxt[3] = k_r.py + k_r.ey;
    end else begin
      cx_nxt[0] = k_r.px - k_ox_r;  cy_nxt[0] = k_r.py - k_oy_r;
      cx_nxt[1] = k_r.px + k_ox_r;  cy_nxt[1] = k_r.py + k_oy_r;
      cx_nxt[2] = k_r.ex + k_ox_r;  cy_nxt[2] = k_r.ey + k_oy_r;
      cx_nxt[3] = k_r.ex - k_ox_r;  cy_nxt[3] = k_r.ey - k_oy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
      l_v_r <= 1'b0;
    end else if (adv) begin
      k_v_r <= d2_v_r[DIV_STAGES-1];
      l_v_r <= k_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r    <= o_end;
      k_ox_r <= o_end.zero ? '0 : apply_sign(q_ox, o_end.dy > 0);
      k_oy_r <= o_end.zero ? '0 : apply_sign(q_oy, o_end.dx < 0);
      for (int c = 0; c < 4; c++) begin
        l_cx_r[c] <= sat16(cx_nxt[c]);
        l_cy_r[c] <= sat16(cy_nxt[c]);
      end
      l_col_r <= k_r.col;
    end
  end

  // Vertex output register: one corner word per cycle while out_tready is high.
  logic        s_v_r;
  logic [2:0]  s_cnt_r;
  logic [15:0] s_cx_r [4];
  logic [15:0] s_cy_r [4];
  logic [31:0] s_col_r;
  logic [1:0]  corner;
  logic        s_last;

  assign s_last   = (s_cnt_r == LAST_VERTEX);
  assign ser_free = !s_v_r || (out_tready && s_last);
  assign ser_load = l_v_r && ser_free;
  assign adv      = !l_v_r || ser_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r   <= 1'b0;
      s_cnt_r <= '0;
    end else if (ser_load) begin
      s_v_r   <= 1'b1;
      s_cnt_r <= '0;
    end else if (s_v_r && out_tready) begin
      if (s_last) s_v_r <= 1'b0;
      else s_cnt_r <= s_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      s_cx_r  <= l_cx_r;
      s_cy_r  <= l_cy_r;
      s_col_r <= l_col_r;
    end
  end

  assign corner     = corner_sel(s_cnt_r);
  assign out_tvalid = s_v_r;
  assign out_tdata  = {s_col_r, s_cy_r[corner], s_cx_r[corner]};
  assign out_tlast  = s_last;

endmodule
